>>> rtl/rga_pkg.sv
// Shared types and constants for the rational arithmetic reduce block.
package rga_pkg;

    typedef logic [2:0] op_t;

    localparam op_t OP_ADD = 3'd0;
    localparam op_t OP_SUB = 3'd1;
    localparam op_t OP_MUL = 3'd2;
    localparam op_t OP_DIV = 3'd3;
    localparam op_t OP_NEG = 3'd4;
    localparam op_t OP_RED = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_FORM,
        ST_EUC_CHECK,
        ST_EUC_DIV,
        ST_QN,
        ST_QD,
        ST_EMIT
    } state_t;

    // Control into the shared divider.
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // Status out of the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

>>> rtl/rga_if.sv
// Valid/ready channel interfaces for the request and the result.
interface rga_req_if #(parameter int WIDTH = 32);
    logic                    valid;
    logic                    ready;
    logic [2:0]              operation;
    logic signed [WIDTH-1:0] a_num;
    logic signed [WIDTH-1:0] a_den;
    logic signed [WIDTH-1:0] b_num;
    logic signed [WIDTH-1:0] b_den;

    modport source (output valid, operation, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, operation, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rga_rsp_if #(parameter int WIDTH = 32);
    logic                    valid;
    logic                    ready;
    logic signed [WIDTH-1:0] res_num;
    logic signed [WIDTH-1:0] res_den;
    logic                    less;
    logic                    equal;
    logic                    greater;
    logic                    undefined;
    logic                    overflow;

    modport source (output valid, res_num, res_den, less, equal, greater, undefined,
                    overflow, input ready);
    modport sink (input valid, res_num, res_den, less, equal, greater, undefined,
                  overflow, output ready);
endinterface

>>> rtl/rational_arith_gcd_reduce_top.sv
// Top level of the rational arithmetic block with Euclid gcd reduction.
//
//  Channel | Dir | Modport | Payload
//  --------+-----+---------+----------------------------------------------------
//  req     | in  | sink    | operation, a_num, a_den, b_num, b_den
//  rsp     | out | source  | res_num, res_den, less, equal, greater, undefined,
//          |     |         | overflow
//
// A request computes four products on the shared multiplier and forms the raw
// fraction, then runs Euclid remainder steps on the shared restoring divider while
// the second operand is nonzero, where M = 2 * WIDTH + 1 is the divider width and
// the divider retires one bit per cycle. It then divides the numerator and the
// denominator by the gcd and writes the result to the output register; the next
// request is taken once the result is emitted. A zero over zero result skips the
// divider. Reset is asynchronous and clears the sequencer and the output valid. A
// result waits in the output register while a new request is already taken; the
// sequencer stalls only when it finishes while the previous result has not yet been
// transferred.
module rational_arith_gcd_reduce_top #(
    parameter int WIDTH = 32
) (
    input logic clk,
    input logic rst_n,
    rga_req_if.sink   req,
    rga_rsp_if.source rsp
);
    import rga_pkg::*;

    localparam int M = 2 * WIDTH + 1;

    state_t state_reg, state_next;

    logic [2:0]       op_reg;
    logic [WIDTH-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic [1:0]       mul_cnt_reg;
    logic [2*WIDTH-1:0] prod_reg [4];

    logic         rn_neg_reg, rd_neg_reg;
    logic [M-1:0] rn_mag_reg, rd_mag_reg;
    logic [M-1:0] x_reg, y_reg, qn_reg;
    logic         parity_reg;
    logic         less_reg, equal_reg, greater_reg;

    logic             out_valid_reg;
    logic [WIDTH-1:0] out_num_reg, out_den_reg;
    logic             out_less_reg, out_equal_reg, out_greater_reg;
    logic             out_undef_reg, out_ovf_reg;

    // Magnitudes of the input parts; the most negative value maps correctly.
    logic [WIDTH-1:0] an_mag, ad_mag, bn_mag, bd_mag;
    logic             an_s, ad_s, bn_s, bd_s;
    assign an_s   = an_reg[WIDTH-1];
    assign ad_s   = ad_reg[WIDTH-1];
    assign bn_s   = bn_reg[WIDTH-1];
    assign bd_s   = bd_reg[WIDTH-1];
    assign an_mag = an_s ? WIDTH'(0) - an_reg : an_reg;
    assign ad_mag = ad_s ? WIDTH'(0) - ad_reg : ad_reg;
    assign bn_mag = bn_s ? WIDTH'(0) - bn_reg : bn_reg;
    assign bd_mag = bd_s ? WIDTH'(0) - bd_reg : bd_reg;

    // Shared multiplier: a_num*b_den, b_num*a_den, a_den*b_den, a_num*b_num.
    logic [WIDTH-1:0]   mul_a, mul_b;
    logic [2*WIDTH-1:0] mul_p;
    always_comb
    begin
        case (mul_cnt_reg)
            2'd0:    begin mul_a = an_mag; mul_b = bd_mag; end
            2'd1:    begin mul_a = bn_mag; mul_b = ad_mag; end
            2'd2:    begin mul_a = ad_mag; mul_b = bd_mag; end
            default: begin mul_a = an_mag; mul_b = bn_mag; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Signed products and the raw fraction, formed in one step.
    logic [M-1:0]        pm, qm, dm, nm;
    logic                p_neg, q_neg, d_neg, n_neg, t_neg;
    logic signed [M-1:0] p_s, q_s;
    logic                sum_neg, form_rn_neg, form_rd_neg;
    logic [M-1:0]        sum_mag, form_rn_mag, form_rd_mag;
    always_comb
    begin
        pm    = {1'b0, prod_reg[0]};
        qm    = {1'b0, prod_reg[1]};
        dm    = {1'b0, prod_reg[2]};
        nm    = {1'b0, prod_reg[3]};
        p_neg = (an_s ^ bd_s) && (pm != '0);
        q_neg = (bn_s ^ ad_s) && (qm != '0);
        d_neg = (ad_s ^ bd_s) && (dm != '0);
        n_neg = (an_s ^ bn_s) && (nm != '0);
        p_s   = p_neg ? $signed(M'(0) - pm) : $signed(pm);
        q_s   = q_neg ? $signed(M'(0) - qm) : $signed(qm);
        t_neg = (op_reg == OP_SUB) ? !q_neg : q_neg;
        if (p_neg == t_neg)
        begin
            sum_neg = p_neg;
            sum_mag = pm + qm;
        end
        else if (pm >= qm)
        begin
            sum_neg = p_neg;
            sum_mag = pm - qm;
        end
        else
        begin
            sum_neg = t_neg;
            sum_mag = qm - pm;
        end
        if (sum_mag == '0)
        begin
            sum_neg = 1'b0;
        end
        case (op_reg) inside
            OP_ADD, OP_SUB:
            begin
                form_rn_neg = sum_neg; form_rn_mag = sum_mag;
                form_rd_neg = d_neg;   form_rd_mag = dm;
            end
            OP_MUL:
            begin
                form_rn_neg = n_neg; form_rn_mag = nm;
                form_rd_neg = d_neg; form_rd_mag = dm;
            end
            OP_DIV:
            begin
                form_rn_neg = p_neg; form_rn_mag = pm;
                form_rd_neg = q_neg; form_rd_mag = qm;
            end
            OP_NEG:
            begin
                form_rn_neg = !an_s && (an_mag != '0);
                form_rn_mag = M'(an_mag);
                form_rd_neg = ad_s;
                form_rd_mag = M'(ad_mag);
            end
            default:
            begin
                form_rn_neg = an_s;
                form_rn_mag = M'(an_mag);
                form_rd_neg = ad_s;
                form_rd_mag = M'(ad_mag);
            end
        endcase
    end

    // Shared divider serves the Euclid remainders and both final quotients.
    div_ctrl_t    div_ctrl;
    div_stat_t    div_stat;
    logic [M-1:0] div_dividend, div_divisor, div_quo, div_rem;

    rga_div #(.N(M)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .stat      (div_stat),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Final signs, range check and truncation to the port width.
    localparam logic [M-1:0] LIM = M'(1) << (WIDTH - 1);
    logic         g_neg, qn_neg, qd_neg, emit_ovf;
    logic [M-1:0] qn_val, qd_val;
    always_comb
    begin
        g_neg    = parity_reg && rd_neg_reg;
        qn_neg   = (rn_neg_reg != g_neg) && (rn_mag_reg != '0);
        qd_neg   = (rd_neg_reg != g_neg) && (rd_mag_reg != '0);
        emit_ovf = (qn_neg ? (qn_reg > LIM) : (qn_reg > LIM - 1'b1)) ||
                   (qd_neg ? (div_quo > LIM) : (div_quo > LIM - 1'b1));
        qn_val   = qn_neg ? M'(0) - qn_reg : qn_reg;
        qd_val   = qd_neg ? M'(0) - div_quo : div_quo;
    end

    logic out_free, accept, undef_now;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign accept    = req.valid && req.ready;
    assign undef_now = (x_reg == '0);

    // Sequencer: next state and divider requests.
    always_comb
    begin
        state_next     = state_reg;
        div_ctrl.start = 1'b0;
        div_dividend   = x_reg;
        div_divisor    = y_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (mul_cnt_reg == 2'd3)
                begin
                    state_next = ST_FORM;
                end
            end
            ST_FORM:
            begin
                state_next = ST_EUC_CHECK;
            end
            ST_EUC_CHECK:
            begin
                if (y_reg != '0)
                begin
                    div_ctrl.start = 1'b1;
                    state_next     = ST_EUC_DIV;
                end
                else if (!undef_now)
                begin
                    div_ctrl.start = 1'b1;
                    div_dividend   = rn_mag_reg;
                    div_divisor    = x_reg;
                    state_next     = ST_QN;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EUC_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_EUC_CHECK;
                end
            end
            ST_QN:
            begin
                if (div_stat.done)
                begin
                    div_ctrl.start = 1'b1;
                    div_dividend   = rd_mag_reg;
                    div_divisor    = x_reg;
                    state_next     = ST_QD;
                end
            end
            ST_QD:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_MUL)
            begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
            end
            else
            begin
                mul_cnt_reg <= '0;
            end
            if (state_reg == ST_EMIT && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // The result stays in the QD state's quotient output until the emit step,
    // because the divider is idle then and holds its last quotient.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg <= req.operation;
            an_reg <= req.a_num;
            ad_reg <= req.a_den;
            bn_reg <= req.b_num;
            bd_reg <= req.b_den;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg[mul_cnt_reg] <= mul_p;
        end
        if (state_reg == ST_FORM)
        begin
            rn_neg_reg  <= form_rn_neg;
            rn_mag_reg  <= form_rn_mag;
            rd_neg_reg  <= form_rd_neg;
            rd_mag_reg  <= form_rd_mag;
            x_reg       <= form_rn_mag;
            y_reg       <= form_rd_mag;
            parity_reg  <= 1'b0;
            less_reg    <= p_s < q_s;
            equal_reg   <= p_s == q_s;
            greater_reg <= p_s > q_s;
        end
        if (state_reg == ST_EUC_DIV && div_stat.done)
        begin
            x_reg      <= y_reg;
            y_reg      <= div_rem;
            parity_reg <= !parity_reg;
        end
        if (state_reg == ST_QN && div_stat.done)
        begin
            qn_reg <= div_quo;
        end
        if (state_reg == ST_EMIT && out_free)
        begin
            out_less_reg    <= less_reg;
            out_equal_reg   <= equal_reg;
            out_greater_reg <= greater_reg;
            out_undef_reg   <= undef_now;
            if (undef_now)
            begin
                out_num_reg <= '0;
                out_den_reg <= '0;
                out_ovf_reg <= 1'b0;
            end
            else
            begin
                out_num_reg <= qn_val[WIDTH-1:0];
                out_den_reg <= qd_val[WIDTH-1:0];
                out_ovf_reg <= emit_ovf;
            end
        end
    end

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.res_num   = out_num_reg;
    assign rsp.res_den   = out_den_reg;
    assign rsp.less      = out_less_reg;
    assign rsp.equal     = out_equal_reg;
    assign rsp.greater   = out_greater_reg;
    assign rsp.undefined = out_undef_reg;
    assign rsp.overflow  = out_ovf_reg;

`ifndef ASSERT_OFF
    // The divider is never started with a zero divisor.
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> div_divisor != '0)
        else $error("divider started with zero divisor");

    // The divider is only started while it is idle.
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    // A Euclid step in progress always has a nonzero second operand.
    a_euc_y: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_EUC_DIV |-> y_reg != '0)
        else $error("Euclid step with zero operand");

    // The divider finishes only while the sequencer is waiting for it.
    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == ST_EUC_DIV || state_reg == ST_QN ||
                           state_reg == ST_QD))
        else $error("divider done outside a wait state");
`endif

endmodule

>>> rtl/rga_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module rga_div #(
    parameter int N = 65
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rga_pkg::div_ctrl_t  ctrl,
    input  logic [N-1:0]        dividend,
    input  logic [N-1:0]        divisor,
    output rga_pkg::div_stat_t  stat,
    output logic [N-1:0]        quotient,
    output logic [N-1:0]        remainder
);
    import rga_pkg::*;

    localparam int CW = $clog2(N + 1);

    logic [N-1:0]  rem_reg, rem_next;
    logic [N-1:0]  quo_reg, quo_next;
    logic [N-1:0]  dsr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [N:0]    trial;
    logic          fits;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[N-1]};
        fits      = trial >= {1'b0, dsr_reg};
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (ctrl.start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            cnt_next  = CW'(N);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? N'(trial - {1'b0, dsr_reg}) : trial[N-1:0];
            quo_next = {quo_reg[N-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (ctrl.start)
        begin
            dsr_reg <= divisor;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule
